// ===== src/hzc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the hierarchical-Z occlusion culler.
package hzc_pkg;

    localparam int TILE_COLS_DEF = 64;
    localparam int TILE_ROWS_DEF = 32;

    localparam int STORE_AW    = 11;
    localparam int STORE_DEPTH = 2048;
    localparam int DEPTH_W     = 16;
    localparam int COORD_W     = 32;
    localparam int SCALE_W     = 24;
    localparam int ID_W        = 23;
    localparam int OFFSET_W    = 31;
    localparam int COUNT_W     = 24;
    localparam int QUOT_W      = 25;
    localparam int S_TDATA_W   = 184;
    localparam int M_TDATA_W   = 104;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_TEST  = 2'd1;
    localparam logic [1:0] MODE_FRAME = 2'd2;

    localparam logic KIND_DRAW  = 1'b0;
    localparam logic KIND_TOTAL = 1'b1;

    localparam logic REG_SCALE_H = 1'b0;
    localparam logic REG_SCALE_V = 1'b1;

    localparam logic [DEPTH_W-1:0] DEPTH_SLACK = 16'd16;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 24'hFFFFFF;
    localparam logic signed [COORD_W-1:0] FAR_LIMIT = 32'sd65536000;

    typedef struct packed {
        logic [1:0]          mode;
        logic [STORE_AW-1:0] tile_index;
        logic [DEPTH_W-1:0]  tile_depth;
        logic [QUOT_W-1:0]   quot_x;
        logic [QUOT_W-1:0]   quot_y;
        logic [DEPTH_W-1:0]  near;
        logic                in_range;
        logic [ID_W-1:0]     draw_id;
    } front_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [DEPTH_W-1:0] near;
        logic               in_range;
        logic [ID_W-1:0]    draw_id;
    } mid_t;

endpackage

// ===== src/hzc_front.sv =====
`timescale 1ns / 1ps
// Input stage: scale registers, tile coordinate products and near depth.
module hzc_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [hzc_pkg::SCALE_W-1:0] cfg_wdata,
    input  logic                        in_valid,
    input  logic                        in_en,
    input  logic [1:0]                  mode,
    input  logic [hzc_pkg::STORE_AW-1:0] tile_index,
    input  logic [hzc_pkg::DEPTH_W-1:0] tile_depth,
    input  logic [hzc_pkg::COORD_W-1:0] box_min_x,
    input  logic [hzc_pkg::COORD_W-1:0] box_min_y,
    input  logic [hzc_pkg::COORD_W-1:0] box_min_z,
    input  logic [hzc_pkg::COORD_W-1:0] box_max_z,
    input  logic [hzc_pkg::ID_W-1:0]    draw_id,
    output logic                        valid_reg,
    output hzc_pkg::front_t             front_reg
);

    logic [hzc_pkg::SCALE_W-1:0] scale_h_reg;
    logic [hzc_pkg::SCALE_W-1:0] scale_v_reg;
    logic signed [56:0]          prod_x;
    logic signed [56:0]          prod_y;
    logic signed [47:0]          near_prod;
    hzc_pkg::front_t             front_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_h_reg <= 24'h010000;
            scale_v_reg <= 24'h010000;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                hzc_pkg::REG_SCALE_H: scale_h_reg <= cfg_wdata;
                hzc_pkg::REG_SCALE_V: scale_v_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign prod_x    = $signed(box_min_x) * $signed({1'b0, scale_h_reg});
    assign prod_y    = $signed(box_min_y) * $signed({1'b0, scale_v_reg});
    // z * 65535 as z * 2^16 - z
    assign near_prod = $signed({box_min_z, 16'h0000})
                     - $signed({{16{box_min_z[31]}}, box_min_z});

    always_comb begin
        front_next.mode       = mode;
        front_next.tile_index = tile_index;
        front_next.tile_depth = tile_depth;
        front_next.quot_x     = prod_x[56:32];
        front_next.quot_y     = prod_y[56:32];
        front_next.near       = near_prod[31:16];
        front_next.in_range   = ($signed(box_max_z) > 32'sd0)
                             && ($signed(box_min_z) < hzc_pkg::FAR_LIMIT);
        front_next.draw_id    = draw_id;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_en && in_valid) begin
            front_reg <= front_next;
        end
    end

endmodule

// ===== src/hzc_tile_store.sv =====
`timescale 1ns / 1ps
// Tile depth memory: tile address clamp, depth writes and registered reads.
module hzc_tile_store #(
    parameter int TILE_COLS = hzc_pkg::TILE_COLS_DEF,
    parameter int TILE_ROWS = hzc_pkg::TILE_ROWS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    input  logic                        in_en,
    input  hzc_pkg::front_t             front,
    output logic                        valid_reg,
    output hzc_pkg::mid_t               mid_reg,
    output logic [hzc_pkg::DEPTH_W-1:0] tile_q_reg
);

    logic [hzc_pkg::DEPTH_W-1:0]  mem [hzc_pkg::STORE_DEPTH];
    logic [hzc_pkg::STORE_AW-1:0] col;
    logic [hzc_pkg::STORE_AW-1:0] row;
    logic [hzc_pkg::STORE_AW-1:0] rd_addr;
    logic                         take;

    assign take = in_en && in_valid;

    always_comb begin
        if ($signed(front.quot_x) < 25'sd0) begin
            col = '0;
        end else if ($signed(front.quot_x) > $signed(25'(TILE_COLS - 1))) begin
            col = 11'(TILE_COLS - 1);
        end else begin
            col = front.quot_x[hzc_pkg::STORE_AW-1:0];
        end
        if ($signed(front.quot_y) < 25'sd0) begin
            row = '0;
        end else if ($signed(front.quot_y) > $signed(25'(TILE_ROWS - 1))) begin
            row = 11'(TILE_ROWS - 1);
        end else begin
            row = front.quot_y[hzc_pkg::STORE_AW-1:0];
        end
        rd_addr = 11'(row * 11'(TILE_COLS) + col);
    end

    always_ff @(posedge aclk) begin
        if (take && front.mode == hzc_pkg::MODE_WRITE) begin
            mem[front.tile_index] <= front.tile_depth;
        end
        if (take && front.mode == hzc_pkg::MODE_TEST) begin
            tile_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            mid_reg.mode     <= front.mode;
            mid_reg.near     <= front.near;
            mid_reg.in_range <= front.in_range;
            mid_reg.draw_id  <= front.draw_id;
        end
    end

endmodule

// ===== src/hzc_test.sv =====
`timescale 1ns / 1ps
// Depth test, visible counter and output register.
module hzc_test (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    input  logic                         in_en,
    input  hzc_pkg::mid_t                mid,
    input  logic [hzc_pkg::DEPTH_W-1:0]  tile_q,
    output logic                         valid_reg,
    output logic                         kind_reg,
    output logic [hzc_pkg::ID_W-1:0]     id_reg,
    output logic [hzc_pkg::OFFSET_W-1:0] offset_reg,
    output logic [hzc_pkg::COUNT_W-1:0]  slot_reg,
    output logic [hzc_pkg::COUNT_W-1:0]  total_reg
);

    logic [hzc_pkg::COUNT_W-1:0] count_reg;
    logic [hzc_pkg::COUNT_W-1:0] count_next;
    logic                        visible;
    logic                        frame;
    logic                        take;

    assign take    = in_en && in_valid;
    assign frame   = mid.mode == hzc_pkg::MODE_FRAME;
    assign visible = (mid.mode == hzc_pkg::MODE_TEST) && mid.in_range
                  && ({1'b0, mid.near} <= ({1'b0, tile_q} + {1'b0, hzc_pkg::DEPTH_SLACK}));

    always_comb begin
        count_next = count_reg;
        if (take && frame) begin
            count_next = '0;
        end else if (take && visible && count_reg != hzc_pkg::COUNT_MAX) begin
            count_next = count_reg + 24'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (in_en) begin
                valid_reg <= in_valid && (visible || frame);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            kind_reg   <= frame ? hzc_pkg::KIND_TOTAL : hzc_pkg::KIND_DRAW;
            id_reg     <= frame ? '0 : mid.draw_id;
            offset_reg <= frame ? '0 : {mid.draw_id, 8'h00};
            slot_reg   <= frame ? '0 : count_reg;
            total_reg  <= frame ? count_reg : '0;
        end
    end

endmodule

// ===== src/hiz_occlusion_cull_dispatch.sv =====
`timescale 1ns / 1ps
// Top level of the hierarchical-Z occlusion culler.
//
//  channel  | direction | handshake          | payload
//  s_       | in        | s_tvalid/s_tready  | s_tuser mode, s_tdata box or tile write
//  m_       | out       | m_tvalid/m_tready  | m_tuser kind, m_tdata draw command or total
//  cfg_     | in        | cfg_wr_en          | cfg_index, cfg_wdata scale registers
//
// One beat per cycle unless a low m_tready stalls the output beat.
// Stages: scale multiply, tile memory access (one port), depth test and count.
// The tile memory is not cleared by reset; the counter and valid flags are.
// Each stage moves when the one after it is empty or moving, so bubbles fill
// while the output beat waits.
module hiz_occlusion_cull_dispatch #(
    parameter int TILE_COLS = hzc_pkg::TILE_COLS_DEF,
    parameter int TILE_ROWS = hzc_pkg::TILE_ROWS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [hzc_pkg::SCALE_W-1:0]   cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tile_index, tile_depth, box_min_x, box_min_y, box_min_z, box_max_z, draw_id
    input  logic [hzc_pkg::S_TDATA_W-1:0] s_tdata,
    // mode
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // visible_draw_id, vertex_offset, stream_slot, visible_total
    output logic [hzc_pkg::M_TDATA_W-1:0] m_tdata,
    // result_kind
    output logic                          m_tuser
);

    logic                         en_front;
    logic                         en_store;
    logic                         en_test;
    logic                         front_valid;
    logic                         mid_valid;
    hzc_pkg::front_t              front;
    hzc_pkg::mid_t                mid;
    logic [hzc_pkg::DEPTH_W-1:0]  tile_q;
    logic [hzc_pkg::ID_W-1:0]     out_id;
    logic [hzc_pkg::OFFSET_W-1:0] out_offset;
    logic [hzc_pkg::COUNT_W-1:0]  out_slot;
    logic [hzc_pkg::COUNT_W-1:0]  out_total;

    assign en_test  = !m_tvalid || m_tready;
    assign en_store = !mid_valid || en_test;
    assign en_front = !front_valid || en_store;
    assign s_tready = en_front;

    hzc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_tvalid),
        .in_en      (en_front),
        .mode       (s_tuser),
        .tile_index (s_tdata[10:0]),
        .tile_depth (s_tdata[26:11]),
        .box_min_x  (s_tdata[58:27]),
        .box_min_y  (s_tdata[90:59]),
        .box_min_z  (s_tdata[122:91]),
        .box_max_z  (s_tdata[154:123]),
        .draw_id    (s_tdata[177:155]),
        .valid_reg  (front_valid),
        .front_reg  (front)
    );

    hzc_tile_store #(
        .TILE_COLS (TILE_COLS),
        .TILE_ROWS (TILE_ROWS)
    ) u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (front_valid),
        .in_en      (en_store),
        .front      (front),
        .valid_reg  (mid_valid),
        .mid_reg    (mid),
        .tile_q_reg (tile_q)
    );

    hzc_test u_test (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (mid_valid),
        .in_en      (en_test),
        .mid        (mid),
        .tile_q     (tile_q),
        .valid_reg  (m_tvalid),
        .kind_reg   (m_tuser),
        .id_reg     (out_id),
        .offset_reg (out_offset),
        .slot_reg   (out_slot),
        .total_reg  (out_total)
    );

    assign m_tdata = {2'b00, out_total, out_slot, out_offset, out_id};

endmodule

// ===== src/hzc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the culler output stream, bound to the top level.
module hzc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [hzc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output beat valid right after reset");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output beat changed");

    a_total_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == hzc_pkg::KIND_TOTAL |-> m_tdata[77:0] == 78'd0)
        else $error("total beat carries command fields");

    a_draw_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == hzc_pkg::KIND_DRAW
        |-> m_tdata[53:23] == {m_tdata[22:0], 8'h00} && m_tdata[101:78] == 24'd0)
        else $error("draw command offset or total mismatch");

endmodule

bind hiz_occlusion_cull_dispatch hzc_checker u_hzc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
